// ===== rtl/frm_pkg.sv =====
// Shared types and constants for the fraction reduction block.
package frm_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

   typedef logic [VALUE_WIDTH-1:0] mag_type;
   typedef logic [CNT_WIDTH-1:0]   cnt_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] numer_in;
      logic signed [VALUE_WIDTH-1:0] denom_in;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] whole_part;
      logic signed [VALUE_WIDTH-1:0] numer_out;
      logic signed [VALUE_WIDTH-1:0] denom_out;
      logic                          zero_denom;
   } rsp_type;

   typedef enum logic [1:0] {
      SEL_ZDEN   = 2'd0,
      SEL_ZNUM   = 2'd1,
      SEL_PROPER = 2'd2,
      SEL_MIXED  = 2'd3
   } out_sel_type;

   typedef struct packed {
      logic        load;
      logic        gcd_step;
      logic        red_start;
      logic        split_start;
      logic        div_step;
      logic        div_pair;
      logic        out_write;
      out_sel_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic denom_zero;
      logic numer_zero;
      logic gcd_done;
      logic div_last;
      logic split_take;
   } dp_sts_type;

endpackage

// ===== rtl/frm_datapath.sv =====
// Datapath: sign handling, binary GCD, two restoring division lanes, result register.
module frm_datapath (
   input  logic                clock,
   input  frm_pkg::req_type    req_data,
   input  frm_pkg::dp_cmd_type cmd,
   output frm_pkg::dp_sts_type sts,
   output frm_pkg::rsp_type    rsp_data
);
   import frm_pkg::*;

   localparam mag_type SIGN_MAG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam mag_type MAG_ZERO = '0;
   localparam mag_type MAG_ONE  = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
   localparam cnt_type CNT_ONE  = {{(CNT_WIDTH-1){1'b0}}, 1'b1};
   localparam cnt_type CNT_LAST = CNT_WIDTH'(VALUE_WIDTH-1);

   function automatic mag_type pack_signed(input logic neg, input mag_type mag);
      pack_signed = neg ? (MAG_ZERO - mag) : mag;
   endfunction

   mag_type a_ff, a_in, b_ff, b_in;
   cnt_type k_ff, k_in;
   logic    nn_ff, nn_in, nd_ff, nd_in;
   logic    dz_ff, dz_in, nz_ff, nz_in;
   mag_type q0_ff, q0_in, q1_ff, q1_in;
   mag_type r0_ff, r0_in, r1_ff, r1_in;
   mag_type d0_ff, d0_in, d1_ff, d1_in;
   cnt_type cnt_ff, cnt_in;
   rsp_type rsp_ff, rsp_in;

   mag_type           mn_raw, md_raw, gcd_val;
   logic              nn_raw, nd_raw, wneg;
   logic [VALUE_WIDTH:0] sh0, sh1, diff0, diff1;
   logic              ge0, ge1;
   logic              split_take;

   // sign/magnitude compare of the reduced fraction, zero counts as non-negative
   always_comb begin
      if (nn_ff != nd_ff) begin
         split_take = !nn_ff;
      end else if (!nn_ff) begin
         split_take = (q0_ff >= q1_ff);
      end else begin
         split_take = (q0_ff <= q1_ff);
      end
   end

   assign sts.split_take = split_take;
   assign sts.denom_zero = dz_ff;
   assign sts.numer_zero = nz_ff;
   assign sts.gcd_done   = (a_ff == MAG_ZERO) || (b_ff == MAG_ZERO);
   assign sts.div_last   = (cnt_ff == CNT_LAST);

   assign nn_raw  = req_data.numer_in[VALUE_WIDTH-1];
   assign nd_raw  = req_data.denom_in[VALUE_WIDTH-1];
   assign mn_raw  = nn_raw ? (MAG_ZERO - mag_type'(req_data.numer_in))
                           : mag_type'(req_data.numer_in);
   assign md_raw  = nd_raw ? (MAG_ZERO - mag_type'(req_data.denom_in))
                           : mag_type'(req_data.denom_in);
   assign gcd_val = (a_ff | b_ff) << k_ff;

   assign sh0   = {r0_ff, q0_ff[VALUE_WIDTH-1]};
   assign sh1   = {r1_ff, q1_ff[VALUE_WIDTH-1]};
   assign diff0 = sh0 - {1'b0, d0_ff};
   assign diff1 = sh1 - {1'b0, d1_ff};
   assign ge0   = (sh0 >= {1'b0, d0_ff});
   assign ge1   = (sh1 >= {1'b0, d1_ff});
   assign wneg  = (nn_ff != nd_ff) && (q0_ff != MAG_ZERO);

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      k_in   = k_ff;
      nn_in  = nn_ff;
      nd_in  = nd_ff;
      dz_in  = dz_ff;
      nz_in  = nz_ff;
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      r0_in  = r0_ff;
      r1_in  = r1_ff;
      d0_in  = d0_ff;
      d1_in  = d1_ff;
      cnt_in = cnt_ff;
      rsp_in = rsp_ff;

      if (cmd.load) begin
         a_in  = mn_raw;
         b_in  = md_raw;
         k_in  = '0;
         // both negative: negate both; the most negative value stays negative
         nn_in = (nn_raw && nd_raw) ? (mn_raw == SIGN_MAG) : nn_raw;
         nd_in = (nn_raw && nd_raw) ? (md_raw == SIGN_MAG) : nd_raw;
         dz_in = (md_raw == MAG_ZERO);
         nz_in = (mn_raw == MAG_ZERO);
         q0_in = mn_raw;
         q1_in = md_raw;
      end

      if (cmd.gcd_step) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + CNT_ONE;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end

      if (cmd.red_start) begin
         r0_in  = '0;
         r1_in  = '0;
         d0_in  = gcd_val;
         d1_in  = gcd_val;
         cnt_in = '0;
      end

      // reuse lane 0 for the whole part; lane 1 keeps the reduced denominator
      if (cmd.split_start) begin
         r0_in  = '0;
         d0_in  = q1_ff;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         r0_in  = ge0 ? diff0[VALUE_WIDTH-1:0] : sh0[VALUE_WIDTH-1:0];
         q0_in  = {q0_ff[VALUE_WIDTH-2:0], ge0};
         cnt_in = cnt_ff + CNT_ONE;
         if (cmd.div_pair) begin
            r1_in = ge1 ? diff1[VALUE_WIDTH-1:0] : sh1[VALUE_WIDTH-1:0];
            q1_in = {q1_ff[VALUE_WIDTH-2:0], ge1};
         end
      end

      if (cmd.out_write) begin
         unique case (cmd.out_sel)
            SEL_ZDEN: begin
               rsp_in.whole_part = '0;
               rsp_in.numer_out  = '0;
               rsp_in.denom_out  = '0;
               rsp_in.zero_denom = 1'b1;
            end
            SEL_ZNUM: begin
               rsp_in.whole_part = '0;
               rsp_in.numer_out  = '0;
               rsp_in.denom_out  = signed'(MAG_ONE);
               rsp_in.zero_denom = 1'b0;
            end
            SEL_PROPER: begin
               rsp_in.whole_part = '0;
               rsp_in.numer_out  = signed'(pack_signed(nn_ff, q0_ff));
               rsp_in.denom_out  = signed'(pack_signed(nd_ff, q1_ff));
               rsp_in.zero_denom = 1'b0;
            end
            SEL_MIXED: begin
               rsp_in.whole_part = signed'(pack_signed(wneg, q0_ff));
               rsp_in.numer_out  = signed'(pack_signed(nn_ff, r0_ff));
               rsp_in.denom_out  = signed'(pack_signed(nd_ff, q1_ff));
               rsp_in.zero_denom = 1'b0;
            end
            default: begin
               rsp_in = rsp_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      nn_ff  <= nn_in;
      nd_ff  <= nd_in;
      dz_ff  <= dz_in;
      nz_ff  <= nz_in;
      q0_ff  <= q0_in;
      q1_ff  <= q1_in;
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      d0_ff  <= d0_in;
      d1_ff  <= d1_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/frm_ctrl.sv =====
// Controller: sequences load, GCD, reduction, split and result hand-off.
module frm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  frm_pkg::dp_sts_type sts,
   output frm_pkg::dp_cmd_type cmd
);
   import frm_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_GCD    = 7'b0000100,
      ST_REDUCE = 7'b0001000,
      ST_CMP    = 7'b0010000,
      ST_SPLIT  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   out_sel_type sel_ff, sel_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      sel_in      = sel_ff;
      cmd         = '0;
      cmd.out_sel = sel_ff;
      req_ready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (sts.denom_zero) begin
               sel_in   = SEL_ZDEN;
               state_in = ST_FINISH;
            end else if (sts.numer_zero) begin
               sel_in   = SEL_ZNUM;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               cmd.red_start = 1'b1;
               state_in      = ST_REDUCE;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_REDUCE: begin
            cmd.div_step = 1'b1;
            cmd.div_pair = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (sts.split_take) begin
               cmd.split_start = 1'b1;
               state_in        = ST_SPLIT;
            end else begin
               sel_in   = SEL_PROPER;
               state_in = ST_FINISH;
            end
         end
         ST_SPLIT: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               sel_in   = SEL_MIXED;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_write = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_ZDEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/fraction_reduce_mixed_top.sv =====
// Fraction reduction to mixed form: takes a signed numerator and denominator,
// reduces them by the GCD of their magnitudes (a zero numerator gives 0/1, and
// when both are negative both are negated) and, where the reduced numerator is
// at least the denominator in a signed compare, splits off a truncated whole
// part and keeps the remainder as the numerator. A zero denominator returns
// zero_denom set with all other fields 0. One transaction is in flight at a
// time; a finished result sits in the output register, so the next
// transaction is taken while it waits. A zero numerator or denominator goes
// from the check straight to the result; any other fraction runs the binary
// GCD loop (one subtract-and-shift per cycle), then the two restoring
// division lanes for the reduction and, where it splits, one lane for the
// whole part.
module fraction_reduce_mixed_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  frm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output frm_pkg::rsp_type rsp_data
);
   import frm_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   frm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   frm_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/frm_checker.sv =====
// Port-level checker for the fraction reduction block, bound to the top level.
module frm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input frm_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input frm_pkg::rsp_type rsp_data
);
   import frm_pkg::*;

   // an error result carries nothing else
   a_zero_denom_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_denom |->
         rsp_data.whole_part == '0 && rsp_data.numer_out == '0 &&
         rsp_data.denom_out == '0)
      else $error("zero_denom result with non-zero fields");

   // a good result never has a zero denominator
   a_denom_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.zero_denom |-> rsp_data.denom_out != '0)
      else $error("result with zero denominator");

   // one transaction at a time: input closes after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready straight after an accept");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting request dropped or changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

endmodule

bind fraction_reduce_mixed_top frm_checker u_frm_checker (.*);
